@@ rtl/core/moving_average_change_tracker_defines.svh @@
// Assertion helpers used by the checker.
`ifndef MOVING_AVERAGE_CHANGE_TRACKER_DEFINES_SVH
`define MOVING_AVERAGE_CHANGE_TRACKER_DEFINES_SVH

// Same-cycle implication, off while reset is high.
`define MACT_ASSERT_IMP(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, off while reset is high.
`define MACT_ASSERT_NXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

// Next-cycle implication that also runs through reset.
`define MACT_ASSERT_NXT_RST(lbl, clk, ante, cons, msg) \
   lbl: assert property (@(posedge clk) (ante) |=> (cons)) \
      else $error(msg);

`endif

@@ rtl/core/mact_pkg.sv @@
package mact_pkg;

   localparam int MACT_HISTORY_DEPTH = 64;

   localparam int PRICE_W = 32;
   localparam int WIN_W   = 7;
   localparam int LAG_W   = 6;
   localparam int DIFF_W  = 33;
   localparam int PCT_W   = 40;
   localparam int FRAC_W  = 16;
   localparam int SCALE_W = 7;
   localparam int SUM_W   = PRICE_W + WIN_W;
   localparam int PROD_W  = PRICE_W + SCALE_W;
   localparam int NUM_W   = PROD_W + FRAC_W;
   localparam int ITER_W  = 6;

   localparam int CSR_ADDR_W = 3;
   localparam int CSR_DATA_W = 32;

   localparam logic [WIN_W-1:0]   WINDOW_RESET = WIN_W'(7);
   localparam logic [LAG_W-1:0]   LAG_RESET    = LAG_W'(1);
   localparam logic [SCALE_W-1:0] PCT_HUNDRED  = SCALE_W'(100);
   localparam logic [NUM_W-1:0]   PCT_SCALE    = NUM_W'(6553600);
   localparam logic [PCT_W-1:0]   PCT_MAX      = {1'b0, {(PCT_W-1){1'b1}}};
   localparam logic [ITER_W-1:0]  AVG_ITERS    = ITER_W'(SUM_W);
   localparam logic [ITER_W-1:0]  PCT_ITERS    = ITER_W'(NUM_W);

   typedef enum logic [0:0] {
      REG_WINDOW = 1'b0,
      REG_LAG    = 1'b1
   } mact_reg_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_SUM,
      ST_LAG,
      ST_LAG_WAIT,
      ST_DIV_AVG,
      ST_PCT_START,
      ST_DIV_PCT,
      ST_DONE
   } mact_state_type;

   typedef struct packed {
      logic accept;
      logic rd_sum;
      logic rd_lag;
      logic lag_capture;
      logic div_avg_start;
      logic avg_capture;
      logic div_pct_start;
      logic pct_capture;
      logic load_out;
   } mact_cmd_type;

   typedef struct packed {
      logic avg_ok;
      logic lag_ok;
      logic sum_last;
      logic div_done;
      logic avg_zero;
      logic out_busy;
   } mact_sts_type;

endpackage

@@ rtl/core/mact_div.sv @@
module mact_div import mact_pkg::*; (
   input  logic                clock,
   input  logic                reset,
   input  logic                start,
   input  logic [NUM_W-1:0]    num,
   input  logic [PRICE_W-1:0]  den,
   input  logic [ITER_W-1:0]   iters,
   output logic                done,
   output logic [NUM_W-1:0]    quot
);

   logic [NUM_W-1:0]   num_ff,  num_in;
   logic [PRICE_W-1:0] den_ff,  den_in;
   logic [PRICE_W-1:0] rem_ff,  rem_in;
   logic [NUM_W-1:0]   quot_ff, quot_in;
   logic [ITER_W-1:0]  cnt_ff,  cnt_in;
   logic               done_ff, done_in;

   logic               busy;
   logic [PRICE_W:0]   rem_sh;
   logic [PRICE_W:0]   diff;
   logic               fits;

   // Restoring division: one quotient bit per cycle, numerator MSB first.
   always_comb begin
      busy    = cnt_ff != '0;
      rem_sh  = {rem_ff, num_ff[NUM_W-1]};
      diff    = rem_sh - {1'b0, den_ff};
      fits    = rem_sh >= {1'b0, den_ff};
      num_in  = num_ff;
      den_in  = den_ff;
      rem_in  = rem_ff;
      quot_in = quot_ff;
      cnt_in  = cnt_ff;
      done_in = busy && (cnt_ff == ITER_W'(1));
      if (start) begin
         num_in  = num;
         den_in  = den;
         rem_in  = '0;
         quot_in = '0;
         cnt_in  = iters;
      end else if (busy) begin
         num_in  = {num_ff[NUM_W-2:0], 1'b0};
         rem_in  = fits ? diff[PRICE_W-1:0] : rem_sh[PRICE_W-1:0];
         quot_in = {quot_ff[NUM_W-2:0], fits};
         cnt_in  = cnt_ff - ITER_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff  <= '0;
         done_ff <= 1'b0;
      end else begin
         cnt_ff  <= cnt_in;
         done_ff <= done_in;
      end
   end

   always_ff @(posedge clock) begin
      num_ff  <= num_in;
      den_ff  <= den_in;
      rem_ff  <= rem_in;
      quot_ff <= quot_in;
   end

   assign done = done_ff;
   assign quot = quot_ff;

endmodule

@@ rtl/core/mact_ctrl.sv @@
module mact_ctrl import mact_pkg::*; (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_valid,
   input  mact_sts_type sts,
   output logic         req_stall,
   output mact_cmd_type cmd
);

   mact_state_type state_ff, state_in;

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) state_in = ST_SUM;
         end
         ST_SUM: begin
            if (!sts.avg_ok || sts.sum_last) state_in = ST_LAG;
         end
         ST_LAG: begin
            state_in = ST_LAG_WAIT;
         end
         ST_LAG_WAIT: begin
            state_in = sts.avg_ok ? ST_DIV_AVG : ST_DONE;
         end
         ST_DIV_AVG: begin
            if (sts.div_done) state_in = ST_PCT_START;
         end
         ST_PCT_START: begin
            state_in = sts.avg_zero ? ST_DONE : ST_DIV_PCT;
         end
         ST_DIV_PCT: begin
            if (sts.div_done) state_in = ST_DONE;
         end
         ST_DONE: begin
            if (!sts.out_busy) state_in = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_comb begin
      cmd = '0;
      unique case (state_ff)
         ST_IDLE:      cmd.accept        = req_valid;
         ST_SUM:       cmd.rd_sum        = sts.avg_ok;
         ST_LAG:       cmd.rd_lag        = sts.lag_ok;
         ST_LAG_WAIT: begin
            cmd.lag_capture   = sts.lag_ok;
            cmd.div_avg_start = sts.avg_ok;
         end
         ST_DIV_AVG:   cmd.avg_capture   = sts.div_done;
         ST_PCT_START: cmd.div_pct_start = !sts.avg_zero;
         ST_DIV_PCT:   cmd.pct_capture   = sts.div_done;
         ST_DONE:      cmd.load_out      = !sts.out_busy;
         default:      cmd = '0;
      endcase
   end

   assign req_stall = state_ff != ST_IDLE;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

@@ rtl/core/mact_dp.sv @@
module mact_dp import mact_pkg::*; #(
   parameter int HISTORY_DEPTH = MACT_HISTORY_DEPTH
) (
   input  logic                     clock,
   input  logic                     reset,
   input  mact_cmd_type             cmd,
   output mact_sts_type             sts,
   input  logic [PRICE_W-1:0]       req_price_sample,
   input  logic [WIN_W-1:0]         window_days,
   input  logic [LAG_W-1:0]         lag_days,
   output logic                     rsp_valid,
   input  logic                     rsp_stall,
   output logic [PRICE_W-1:0]       rsp_window_mean,
   output logic signed [DIFF_W-1:0] rsp_change_from_average,
   output logic signed [DIFF_W-1:0] rsp_change_from_lag,
   output logic signed [PCT_W-1:0]  rsp_percent_change,
   output logic                     rsp_average_valid,
   output logic                     rsp_lag_valid,
   output logic                     rsp_percent_valid
);

   localparam int PTR_W = (HISTORY_DEPTH > 1) ? $clog2(HISTORY_DEPTH) : 1;
   localparam int CNT_W = $clog2(HISTORY_DEPTH + 1);
   localparam int CMP_W = ((CNT_W > WIN_W) ? CNT_W : WIN_W) + 1;
   localparam int IDX_W = ((PTR_W > LAG_W) ? PTR_W : LAG_W) + 1;
   localparam logic [PTR_W-1:0] LAST_PTR  = PTR_W'(HISTORY_DEPTH - 1);
   localparam logic [CNT_W-1:0] DEPTH_CNT = CNT_W'(HISTORY_DEPTH);

   logic [PRICE_W-1:0] price_hist_ff [HISTORY_DEPTH];

   logic [PTR_W-1:0]   wp_ff,        wp_in;
   logic [CNT_W-1:0]   cnt_ff,       cnt_in;
   logic [PTR_W-1:0]   newest_ff,    newest_in;
   logic [PTR_W-1:0]   rd_ptr_ff,    rd_ptr_in;
   logic [WIN_W-1:0]   k_ff,         k_in;
   logic               rd_sum_d_ff,  rd_sum_d_in;
   logic [PRICE_W-1:0] rd_data_ff;
   logic [PRICE_W-1:0] price_ff,     price_in;
   logic [PROD_W-1:0]  prod_ff,      prod_in;
   logic [SUM_W-1:0]   sum_ff,       sum_in;
   logic               avg_ok_ff,    avg_ok_in;
   logic               lag_ok_ff,    lag_ok_in;
   logic [PRICE_W-1:0] avg_ff,       avg_in;
   logic [DIFF_W-1:0]  chg_lag_ff,   chg_lag_in;
   logic [PCT_W-1:0]   pct_ff,       pct_in;

   logic               rsp_valid_ff, rsp_valid_in;
   logic [PRICE_W-1:0] out_avg_ff,   out_avg_in;
   logic [DIFF_W-1:0]  out_chg_avg_ff, out_chg_avg_in;
   logic [DIFF_W-1:0]  out_chg_lag_ff, out_chg_lag_in;
   logic [PCT_W-1:0]   out_pct_ff,   out_pct_in;
   logic               out_avg_ok_ff, out_avg_ok_in;
   logic               out_lag_ok_ff, out_lag_ok_in;
   logic               out_pct_ok_ff, out_pct_ok_in;

   logic [CNT_W-1:0]   cnt_next;
   logic [IDX_W-1:0]   newest_x;
   logic [IDX_W-1:0]   lag_x;
   logic [IDX_W-1:0]   lag_addr_x;
   logic [PTR_W-1:0]   lag_addr;
   logic [PTR_W-1:0]   rd_addr;
   logic               rd_en;
   logic               pct_ok;

   logic               div_start;
   logic [NUM_W-1:0]   div_num;
   logic [PRICE_W-1:0] div_den;
   logic [ITER_W-1:0]  div_iters;
   logic               div_done;
   logic [NUM_W-1:0]   div_quot;
   logic [NUM_W-1:0]   pct_raw;

   mact_div u_div (
      .clock (clock),
      .reset (reset),
      .start (div_start),
      .num   (div_num),
      .den   (div_den),
      .iters (div_iters),
      .done  (div_done),
      .quot  (div_quot)
   );

   // Divider operands: window sum first, then scaled price over the mean.
   always_comb begin
      div_start = cmd.div_avg_start | cmd.div_pct_start;
      if (cmd.div_pct_start) begin
         div_num   = {prod_ff, {FRAC_W{1'b0}}};
         div_den   = avg_ff;
         div_iters = PCT_ITERS;
      end else begin
         div_num   = {sum_ff, {FRAC_W{1'b0}}};
         div_den   = PRICE_W'(window_days);
         div_iters = AVG_ITERS;
      end
   end

   // Sample lag_days back from the newest slot, wrapping around the ring.
   always_comb begin
      newest_x = IDX_W'(newest_ff);
      lag_x    = IDX_W'(lag_days);
      if (newest_x >= lag_x) begin
         lag_addr_x = newest_x - lag_x;
      end else begin
         lag_addr_x = newest_x + IDX_W'(HISTORY_DEPTH) - lag_x;
      end
      lag_addr = lag_addr_x[PTR_W-1:0];
      rd_en    = cmd.rd_sum | cmd.rd_lag;
      rd_addr  = cmd.rd_lag ? lag_addr : rd_ptr_ff;
   end

   always_ff @(posedge clock) begin
      if (cmd.accept) price_hist_ff[wp_ff] <= req_price_sample;
      if (rd_en) rd_data_ff <= price_hist_ff[rd_addr];
   end

   always_comb begin
      cnt_next    = (cnt_ff == DEPTH_CNT) ? cnt_ff : cnt_ff + CNT_W'(1);
      wp_in       = wp_ff;
      cnt_in      = cnt_ff;
      newest_in   = newest_ff;
      rd_ptr_in   = rd_ptr_ff;
      k_in        = k_ff;
      price_in    = price_ff;
      prod_in     = prod_ff;
      avg_ok_in   = avg_ok_ff;
      lag_ok_in   = lag_ok_ff;
      rd_sum_d_in = cmd.rd_sum;
      sum_in      = sum_ff;
      if (cmd.accept) begin
         wp_in     = (wp_ff == LAST_PTR) ? '0 : wp_ff + PTR_W'(1);
         cnt_in    = cnt_next;
         newest_in = wp_ff;
         rd_ptr_in = wp_ff;
         k_in      = '0;
         price_in  = req_price_sample;
         prod_in   = PROD_W'(req_price_sample) * PROD_W'(PCT_HUNDRED);
         avg_ok_in = (window_days != '0) && (CMP_W'(window_days) <= CMP_W'(cnt_next));
         lag_ok_in = CMP_W'(lag_days) < CMP_W'(cnt_next);
         sum_in    = '0;
      end else begin
         if (cmd.rd_sum) begin
            rd_ptr_in = (rd_ptr_ff == '0) ? LAST_PTR : rd_ptr_ff - PTR_W'(1);
            k_in      = k_ff + WIN_W'(1);
         end
         // Read data lands in the cycle after its address.
         if (rd_sum_d_ff) sum_in = sum_ff + SUM_W'(rd_data_ff);
      end
   end

   always_comb begin
      pct_raw    = div_quot - PCT_SCALE;
      chg_lag_in = cmd.lag_capture ? {1'b0, price_ff} - {1'b0, rd_data_ff} : chg_lag_ff;
      avg_in     = cmd.avg_capture ? div_quot[PRICE_W-1:0] : avg_ff;
      pct_in     = pct_ff;
      if (cmd.pct_capture) begin
         if (div_quot >= PCT_SCALE && pct_raw > NUM_W'(PCT_MAX)) begin
            pct_in = PCT_MAX;
         end else begin
            pct_in = pct_raw[PCT_W-1:0];
         end
      end
   end

   // Output register: hold while stalled, zero the fields whose flag is low.
   always_comb begin
      pct_ok         = avg_ok_ff && (avg_ff != '0);
      rsp_valid_in   = rsp_valid_ff && rsp_stall;
      out_avg_in     = out_avg_ff;
      out_chg_avg_in = out_chg_avg_ff;
      out_chg_lag_in = out_chg_lag_ff;
      out_pct_in     = out_pct_ff;
      out_avg_ok_in  = out_avg_ok_ff;
      out_lag_ok_in  = out_lag_ok_ff;
      out_pct_ok_in  = out_pct_ok_ff;
      if (cmd.load_out) begin
         rsp_valid_in   = 1'b1;
         out_avg_in     = avg_ok_ff ? avg_ff : '0;
         out_chg_avg_in = avg_ok_ff ? {1'b0, price_ff} - {1'b0, avg_ff} : '0;
         out_chg_lag_in = lag_ok_ff ? chg_lag_ff : '0;
         out_pct_in     = pct_ok ? pct_ff : '0;
         out_avg_ok_in  = avg_ok_ff;
         out_lag_ok_in  = lag_ok_ff;
         out_pct_ok_in  = pct_ok;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wp_ff        <= '0;
         cnt_ff       <= '0;
         rd_sum_d_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         wp_ff        <= wp_in;
         cnt_ff       <= cnt_in;
         rd_sum_d_ff  <= rd_sum_d_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      newest_ff      <= newest_in;
      rd_ptr_ff      <= rd_ptr_in;
      k_ff           <= k_in;
      price_ff       <= price_in;
      prod_ff        <= prod_in;
      sum_ff         <= sum_in;
      avg_ok_ff      <= avg_ok_in;
      lag_ok_ff      <= lag_ok_in;
      avg_ff         <= avg_in;
      chg_lag_ff     <= chg_lag_in;
      pct_ff         <= pct_in;
      out_avg_ff     <= out_avg_in;
      out_chg_avg_ff <= out_chg_avg_in;
      out_chg_lag_ff <= out_chg_lag_in;
      out_pct_ff     <= out_pct_in;
      out_avg_ok_ff  <= out_avg_ok_in;
      out_lag_ok_ff  <= out_lag_ok_in;
      out_pct_ok_ff  <= out_pct_ok_in;
   end

   always_comb begin
      sts.avg_ok   = avg_ok_ff;
      sts.lag_ok   = lag_ok_ff;
      sts.sum_last = k_ff == (window_days - WIN_W'(1));
      sts.div_done = div_done;
      sts.avg_zero = avg_ff == '0;
      sts.out_busy = rsp_valid_ff && rsp_stall;
   end

   assign rsp_valid               = rsp_valid_ff;
   assign rsp_window_mean         = out_avg_ff;
   assign rsp_change_from_average = $signed(out_chg_avg_ff);
   assign rsp_change_from_lag     = $signed(out_chg_lag_ff);
   assign rsp_percent_change      = $signed(out_pct_ff);
   assign rsp_average_valid       = out_avg_ok_ff;
   assign rsp_lag_valid           = out_lag_ok_ff;
   assign rsp_percent_valid       = out_pct_ok_ff;

endmodule

@@ rtl/core/moving_average_change_tracker.sv @@
// Channel   Direction  Handshake          Payload
// req_      in         req_valid/stall    price_sample (Q16.16)
// rsp_      out        rsp_valid/stall    mean, two changes, percent, three flags
// csr_      in/out     APB psel/penable   window_days @0x0, lag_days @0x4
//
// One request at a time. Once a request is taken and the mean is valid and nonzero, the
// steps run in order: one history read per sample, the lag read, then the shared divider
// at one quotient bit per cycle (a 39-bit quotient for the mean, a setup state, a 55-bit
// quotient for percent), and last the result load. A zero mean skips percent; with no
// valid mean the result loads after the lag read, with no history sum or division.
// req_stall drops in the cycle after the load. Reset is synchronous and clears the write
// pointer, sample count and control; history is not cleared. A stalled result holds;
// the next request is taken while it waits, and its result loads once the first is taken.
module moving_average_change_tracker import mact_pkg::*; #(
   parameter int HISTORY_DEPTH = MACT_HISTORY_DEPTH
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_valid,
   output logic                     req_stall,
   input  logic [PRICE_W-1:0]       req_price_sample,
   output logic                     rsp_valid,
   input  logic                     rsp_stall,
   output logic [PRICE_W-1:0]       rsp_window_mean,
   output logic signed [DIFF_W-1:0] rsp_change_from_average,
   output logic signed [DIFF_W-1:0] rsp_change_from_lag,
   output logic signed [PCT_W-1:0]  rsp_percent_change,
   output logic                     rsp_average_valid,
   output logic                     rsp_lag_valid,
   output logic                     rsp_percent_valid,
   input  logic                     csr_psel,
   input  logic                     csr_penable,
   input  logic                     csr_pwrite,
   input  logic [CSR_ADDR_W-1:0]    csr_paddr,
   input  logic [CSR_DATA_W-1:0]    csr_pwdata,
   output logic [CSR_DATA_W-1:0]    csr_prdata,
   output logic                     csr_pready
);

   logic [WIN_W-1:0] window_ff, window_in;
   logic [LAG_W-1:0] lag_ff,    lag_in;
   mact_reg_type     reg_sel;
   logic             csr_write;

   mact_cmd_type     cmd;
   mact_sts_type     sts;

   always_comb begin
      reg_sel   = mact_reg_type'(csr_paddr[CSR_ADDR_W-1]);
      csr_write = csr_psel && csr_penable && csr_pwrite && csr_pready;
      window_in = window_ff;
      lag_in    = lag_ff;
      unique case (reg_sel)
         REG_WINDOW: begin
            csr_prdata = CSR_DATA_W'(window_ff);
            if (csr_write) window_in = csr_pwdata[WIN_W-1:0];
         end
         REG_LAG: begin
            csr_prdata = CSR_DATA_W'(lag_ff);
            if (csr_write) lag_in = csr_pwdata[LAG_W-1:0];
         end
         default: begin
            csr_prdata = '0;
         end
      endcase
   end

   assign csr_pready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         window_ff <= WINDOW_RESET;
         lag_ff    <= LAG_RESET;
      end else begin
         window_ff <= window_in;
         lag_ff    <= lag_in;
      end
   end

   mact_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .sts       (sts),
      .req_stall (req_stall),
      .cmd       (cmd)
   );

   mact_dp #(
      .HISTORY_DEPTH (HISTORY_DEPTH)
   ) u_dp (
      .clock                   (clock),
      .reset                   (reset),
      .cmd                     (cmd),
      .sts                     (sts),
      .req_price_sample        (req_price_sample),
      .window_days             (window_ff),
      .lag_days                (lag_ff),
      .rsp_valid               (rsp_valid),
      .rsp_stall               (rsp_stall),
      .rsp_window_mean         (rsp_window_mean),
      .rsp_change_from_average (rsp_change_from_average),
      .rsp_change_from_lag     (rsp_change_from_lag),
      .rsp_percent_change      (rsp_percent_change),
      .rsp_average_valid       (rsp_average_valid),
      .rsp_lag_valid           (rsp_lag_valid),
      .rsp_percent_valid       (rsp_percent_valid)
   );

endmodule

@@ rtl/core/mact_checker.sv @@
`include "moving_average_change_tracker_defines.svh"

module mact_checker import mact_pkg::*; (
   input logic                     clock,
   input logic                     reset,
   input logic                     req_valid,
   input logic                     req_stall,
   input logic                     rsp_valid,
   input logic                     rsp_stall,
   input logic [PRICE_W-1:0]       rsp_window_mean,
   input logic signed [DIFF_W-1:0] rsp_change_from_lag,
   input logic signed [PCT_W-1:0]  rsp_percent_change,
   input logic                     rsp_average_valid,
   input logic                     rsp_percent_valid
);

   `MACT_ASSERT_NXT_RST(a_reset_clears, clock, reset, !rsp_valid && !req_stall, "reset did not clear handshakes")

   `MACT_ASSERT_NXT(a_one_at_a_time, clock, reset, req_valid && !req_stall, req_stall, "request taken while busy")

   `MACT_ASSERT_NXT(a_rsp_hold, clock, reset, rsp_valid && rsp_stall, rsp_valid && $stable(rsp_window_mean) && $stable(rsp_percent_change) && $stable(rsp_change_from_lag), "stalled result changed")

   `MACT_ASSERT_IMP(a_pct_needs_avg, clock, reset, rsp_valid && rsp_percent_valid, rsp_average_valid && rsp_window_mean != '0, "percent valid without nonzero mean")

   `MACT_ASSERT_IMP(a_no_avg_zeros, clock, reset, rsp_valid && !rsp_average_valid, rsp_window_mean == '0 && rsp_percent_change == '0 && !rsp_percent_valid, "invalid mean carries data")

endmodule

bind moving_average_change_tracker mact_checker u_mact_checker (.*);
